>>> hw/rtl/planar_odometry_integrator_top_assert.svh
// assertion macros shared by the port checkers of the odometry integrator
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH

// same-cycle implication
`define POI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("odometry port check failed");

// next-cycle implication
`define POI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("odometry port check failed");

`endif

>>> hw/rtl/poi_pkg.sv
// shared constants, types and the arctangent table of the odometry integrator
// no dependencies
`default_nettype none

package poi_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	// cordic datapath width and angle accumulator width
	localparam int CW = 52;
	localparam int ZW = 34;

	localparam logic [29:0] NS_PER_S    = 30'd1000000000;
	localparam logic [63:0] DT_NS_LIMIT = 64'd32768000000000;
	localparam logic [31:0] GAIN_Q32    = 32'd2608131496;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_X    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_HEAD = 4'd3;

	localparam logic FUNC_VEL = 1'b0;
	localparam logic FUNC_RST = 1'b1;

	typedef struct packed {
		logic        start;
		logic [31:0] ang;
	} cordic_ctl_t;

	function automatic logic [31:0] atan_step(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/poi_cordic.sv
// iterative cordic rotator, one micro-rotation per cycle
// depends on poi_pkg
`default_nettype none

module poi_cordic import poi_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cordic_ctl_t          ctl,
	input  wire logic signed [CW-1:0] x0,
	input  wire logic signed [CW-1:0] y0,
	output logic                      done,
	output logic signed [CW-1:0]      rx,
	output logic signed [CW-1:0]      ry
);

	localparam int SCW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [SCW-1:0] LAST = SCW'(CORDIC_STEPS - 1);

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [SCW-1:0]       cnt_q;
	logic                 busy_q, done_q;

	logic                 flip;
	logic [31:0]          angf;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] at;

	// fold the left half-plane onto the right one
	assign flip = ctl.ang[31] ^ ctl.ang[30];
	assign angf = ctl.ang + (flip ? 32'h80000000 : 32'h0);
	assign dx   = y_q >>> cnt_q;
	assign dy   = x_q >>> cnt_q;
	assign at   = $signed({2'b00, atan_step(5'(cnt_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= flip ? -x0 : x0;
			y_q <= flip ? -y0 : y0;
			z_q <= $signed({{(ZW-32){angf[31]}}, angf});
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign rx   = x_q;
	assign ry   = y_q;

endmodule

`default_nettype wire

>>> hw/rtl/planar_odometry_integrator_top.sv
// planar dead-reckoning pose integrator, top level
// depends on poi_pkg and poi_cordic
`default_nettype none

// Takes one request at a time. A pose reset request passes through the
// reset state and then loads the output register once the output slot is
// free. A velocity request runs through bit-serial units one after another:
// the stamp difference times 1e9 together with the gain prescale, sign and
// clamp, the restoring divide by 1e9 that yields dt in 2^-32 s, the
// turn_rate by dt product, the CORDIC rotation, the dt by velocity products
// for x and y in parallel and saturation. A finished result waits in the
// output register while the next request is taken. Configuration writes are
// taken at once and load the matching pose component as well.
module planar_odometry_integrator_top import poi_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 func,
	input  wire logic [31:0]          stamp_sec,
	input  wire logic [29:0]          stamp_nsec,
	input  wire logic signed [31:0]   velocity_x,
	input  wire logic signed [31:0]   velocity_y,
	input  wire logic signed [31:0]   turn_rate,
	input  wire logic signed [31:0]   new_x,
	input  wire logic signed [31:0]   new_y,
	input  wire logic [31:0]          new_heading,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        pos_x,
	output logic signed [31:0]        pos_y,
	output logic [31:0]               heading,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RST  = 4'd1;
	localparam logic [3:0] ST_NS   = 4'd2;
	localparam logic [3:0] ST_FIX  = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_SIGN = 4'd5;
	localparam logic [3:0] ST_PROD = 4'd6;
	localparam logic [3:0] ST_ANG  = 4'd7;
	localparam logic [3:0] ST_ROT  = 4'd8;
	localparam logic [3:0] ST_MUL  = 4'd9;
	localparam logic [3:0] ST_SAT  = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	localparam logic [5:0] NS_LAST   = 6'd32;
	localparam logic [5:0] FIX_LAST  = 6'd2;
	localparam logic [5:0] DIV_LAST  = 6'd47;
	localparam logic [5:0] PROD_LAST = 6'd31;
	localparam logic [5:0] MUL_LAST  = 6'd47;

	localparam logic signed [CW+1:0] PMAX = {{(CW-29){1'b0}}, {31{1'b1}}};
	localparam logic signed [CW+1:0] PMIN = {{(CW-29){1'b1}}, {31{1'b0}}};

	// control state
	logic [3:0]         state_q;
	logic [5:0]         cnt_q;
	logic               out_valid_q;
	logic               mode_q;
	logic signed [31:0] cur_x_q, cur_y_q;
	logic [31:0]        cur_h_q;
	logic [31:0]        last_sec_q;
	logic [29:0]        last_nsec_q;
	logic               seen_q;

	// payload
	logic signed [32:0] sd_q;
	logic signed [30:0] nd_q;
	logic [31:0]        sec_q;
	logic [29:0]        nsec_q;
	logic signed [31:0] vx_q, vy_q;
	logic [31:0]        tr_q;
	logic signed [31:0] nx_q, ny_q;
	logic [31:0]        nh_q;
	logic [32:0]        gsr_q;
	logic signed [63:0] acc_q;
	logic signed [64:0] gx_q, gy_q;
	logic               neg_q;
	logic [29:0]        rem_q;
	logic [47:0]        dsr_q;
	logic [48:0]        dt_q;
	logic [48:0]        hp_q;
	logic [CW-1:0]      mx_q, my_q;
	logic [CW:0]        ax_q, ay_q;
	logic               sgx_q, sgy_q;
	logic signed [31:0] px_q, py_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        hd_q;

	logic               in_acc, slot_free, res_load;
	logic signed [63:0] ns_t;
	logic signed [64:0] gx_t, gy_t;
	logic [63:0]        m_clamp;
	logic [30:0]        dv_t;
	logic               dv_ge;
	logic [48:0]        pt;
	logic [CW:0]        ax_sum, ay_sum;
	logic signed [CW+1:0] dxs, dys, sum_x, sum_y;
	logic [31:0]        hd_next;

	cordic_ctl_t          cord_ctl;
	logic                 cord_done;
	logic signed [CW-1:0] cord_x0, cord_y0, cord_rx, cord_ry;

	function automatic logic signed [31:0] sat32(input logic signed [CW+1:0] s);
		logic signed [31:0] r;
		if (s > PMAX) r = 32'sh7FFFFFFF;
		else if (s < PMIN) r = 32'sh80000000;
		else r = s[31:0];
		return r;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign res_load  = ((state_q == ST_RST) || (state_q == ST_DONE)) && slot_free;
	assign cfg_ready = 1'b1;

	assign ns_t    = sd_q[32] ? $signed({34'd0, NS_PER_S}) : 64'sd0;
	assign gx_t    = gsr_q[32] ? $signed({{33{vx_q[31]}}, vx_q}) : 65'sd0;
	assign gy_t    = gsr_q[32] ? $signed({{33{vy_q[31]}}, vy_q}) : 65'sd0;
	assign m_clamp = !seen_q ? 64'd0 :
	                 ($unsigned(acc_q) > DT_NS_LIMIT) ? DT_NS_LIMIT : $unsigned(acc_q);
	assign dv_t    = {rem_q, dsr_q[47]};
	assign dv_ge   = dv_t >= {1'b0, NS_PER_S};
	assign pt      = tr_q[31] ? dt_q : 49'd0;
	assign ax_sum  = ax_q + (dsr_q[0] ? {1'b0, mx_q} : '0);
	assign ay_sum  = ay_q + (dsr_q[0] ? {1'b0, my_q} : '0);
	assign dxs     = sgx_q ? -$signed({1'b0, ax_q}) : $signed({1'b0, ax_q});
	assign dys     = sgy_q ? -$signed({1'b0, ay_q}) : $signed({1'b0, ay_q});
	assign sum_x   = $signed({{(CW-30){cur_x_q[31]}}, cur_x_q}) + dxs;
	assign sum_y   = $signed({{(CW-30){cur_y_q[31]}}, cur_y_q}) + dys;
	assign hd_next = cur_h_q + hp_q[47:16];

	// prescaled velocity, floor of product over 2^16
	assign cord_x0 = $signed({{(CW-49){gx_q[64]}}, gx_q[64:16]});
	assign cord_y0 = $signed({{(CW-49){gy_q[64]}}, gy_q[64:16]});
	assign cord_ctl.start = (state_q == ST_ANG);
	assign cord_ctl.ang   = cur_h_q + (mode_q ? hp_q[48:17] : 32'd0);

	poi_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cord_ctl),
		.x0    (cord_x0),
		.y0    (cord_y0),
		.done  (cord_done),
		.rx    (cord_rx),
		.ry    (cord_ry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_h_q     <= '0;
			last_sec_q  <= '0;
			last_nsec_q <= '0;
			seen_q      <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= (func == FUNC_RST) ? ST_RST : ST_NS;
					end
				end
				ST_RST: begin
					if (slot_free) begin
						cur_x_q     <= nx_q;
						cur_y_q     <= ny_q;
						cur_h_q     <= nh_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_NS: begin
					if (cnt_q == NS_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_FIX;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIX: begin
					if (cnt_q == FIX_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_SIGN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SIGN: begin
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					if (cnt_q == PROD_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_ANG;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ANG: begin
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (cord_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_SAT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SAT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						cur_x_q     <= px_q;
						cur_y_q     <= py_q;
						cur_h_q     <= hd_next;
						last_sec_q  <= sec_q;
						last_nsec_q <= nsec_q;
						seen_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE:      mode_q  <= cfg_data[0];
					CFG_INIT_X:    cur_x_q <= cfg_data;
					CFG_INIT_Y:    cur_y_q <= cfg_data;
					CFG_INIT_HEAD: cur_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sd_q   <= $signed({1'b0, stamp_sec} - {1'b0, last_sec_q});
					nd_q   <= $signed({1'b0, stamp_nsec} - {1'b0, last_nsec_q});
					sec_q  <= stamp_sec;
					nsec_q <= stamp_nsec;
					vx_q   <= velocity_x;
					vy_q   <= velocity_y;
					tr_q   <= turn_rate;
					nx_q   <= new_x;
					ny_q   <= new_y;
					nh_q   <= new_heading;
					gsr_q  <= {1'b0, GAIN_Q32};
					acc_q  <= '0;
					gx_q   <= '0;
					gy_q   <= '0;
				end
			end
			ST_RST: begin
				if (slot_free) begin
					pos_x_q <= cur_x_q;
					pos_y_q <= cur_y_q;
					hd_q    <= cur_h_q;
				end
			end
			ST_NS: begin
				// msb-first horner, top bit of the stamp difference weighs negative
				acc_q <= (acc_q <<< 1) + ((cnt_q == '0) ? -ns_t : ns_t);
				gx_q  <= (gx_q <<< 1) + gx_t;
				gy_q  <= (gy_q <<< 1) + gy_t;
				sd_q  <= sd_q <<< 1;
				gsr_q <= gsr_q << 1;
			end
			ST_FIX: begin
				case (cnt_q)
					6'd0: acc_q <= acc_q + $signed({{33{nd_q[30]}}, nd_q});
					6'd1: begin
						neg_q <= acc_q[63];
						acc_q <= acc_q[63] ? -acc_q : acc_q;
					end
					default: begin
						// quotient bits above 2^47 are known zero
						rem_q <= {1'b0, m_clamp[44:16]};
						dsr_q <= {m_clamp[15:0], 32'd0};
					end
				endcase
			end
			ST_DIV: begin
				rem_q <= dv_ge ? 30'(dv_t - {1'b0, NS_PER_S}) : dv_t[29:0];
				dsr_q <= {dsr_q[46:0], dv_ge};
			end
			ST_SIGN: begin
				dt_q <= neg_q ? (49'd0 - {1'b0, dsr_q}) : {1'b0, dsr_q};
				hp_q <= '0;
			end
			ST_PROD: begin
				hp_q <= (hp_q << 1) + ((cnt_q == '0) ? (49'd0 - pt) : pt);
				tr_q <= tr_q << 1;
			end
			ST_ROT: begin
				if (cord_done) begin
					mx_q  <= cord_rx[CW-1] ? CW'(-cord_rx) : CW'(cord_rx);
					my_q  <= cord_ry[CW-1] ? CW'(-cord_ry) : CW'(cord_ry);
					sgx_q <= neg_q ^ cord_rx[CW-1];
					sgy_q <= neg_q ^ cord_ry[CW-1];
					ax_q  <= '0;
					ay_q  <= '0;
				end
			end
			ST_MUL: begin
				// lsb-first over |dt|, shifted-out bits are the discarded fraction
				ax_q  <= ax_sum >> 1;
				ay_q  <= ay_sum >> 1;
				dsr_q <= dsr_q >> 1;
			end
			ST_SAT: begin
				px_q <= sat32(sum_x);
				py_q <= sat32(sum_y);
			end
			ST_DONE: begin
				if (slot_free) begin
					pos_x_q <= px_q;
					pos_y_q <= py_q;
					hd_q    <= hd_next;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = hd_q;

endmodule

`default_nettype wire

>>> hw/rtl/poi_checker.sv
// port-level checker for the odometry integrator, bound to the top level
// depends on poi_pkg and planar_odometry_integrator_top_assert.svh
`default_nettype none

`include "planar_odometry_integrator_top_assert.svh"

module poi_checker import poi_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic signed [31:0]   pos_x,
	input wire logic signed [31:0]   pos_y,
	input wire logic [31:0]          heading
);

	logic [1:0] pend_q;
	logic       ia, oa;

	assign ia = in_valid && in_ready;
	assign oa = out_valid && out_ready;

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({ia, oa})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`POI_ASSERT_IMP(a_out_has_request, out_valid, pend_q != 2'd0)
	`POI_ASSERT_IMP(a_full_blocks_input, pend_q == 2'd2, !in_ready)
	`POI_ASSERT_NXT(a_one_request_at_a_time, ia, !in_ready)
	`POI_ASSERT_NXT(a_result_held, out_valid && !out_ready,
		out_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading))

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (.*);

`default_nettype wire

>>> tb/odometry_checker.sv
// watches the request, result and register channels of the odometry integrator,
// keeps its own pose, predicts each result and compares; depends on poi_pkg
`timescale 1ns / 1ps

module odometry_checker import poi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic                 func,
	input  wire logic [31:0]          stamp_sec,
	input  wire logic [29:0]          stamp_nsec,
	input  wire logic signed [31:0]   velocity_x,
	input  wire logic signed [31:0]   velocity_y,
	input  wire logic signed [31:0]   turn_rate,
	input  wire logic signed [31:0]   new_x,
	input  wire logic signed [31:0]   new_y,
	input  wire logic [31:0]          new_heading,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic [31:0]          heading,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        results_seen
);

	localparam int ROT_STEPS = 24;
	localparam longint ONE_SEC_NS = 1000000000;
	localparam longint GAP_LIMIT_NS = 64'd32768000000000;
	localparam longint CORDIC_GAIN = 64'd2608131496;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] h;
	} pose_t;

	logic [31:0] arctan_lut [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	logic        midpoint;
	logic [31:0] px, py, ph, prev_sec;
	logic [29:0] prev_nsec;
	logic        have_stamp;
	pose_t       pose_q [$];

	// (a*b) >> 48 with the magnitude truncated, sign applied afterwards
	function automatic longint scale_by_dt(longint a, longint b);
		logic [63:0]  ua, ub, r;
		logic [127:0] p;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'b0, ua} * {64'b0, ub};
		r = {1'b0, p[110:48]};
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] clamp_add(logic [31:0] pos, longint d);
		longint s;
		s = longint'($signed(pos)) + d;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic pose_t integrate_pose();
		pose_t       r;
		longint      ns, dt, prod, x, y, z, dx, dy;
		logic [63:0] m;
		logic [31:0] ang;
		dt = 0;
		if (have_stamp) begin
			ns = (longint'({32'b0, stamp_sec}) - longint'({32'b0, prev_sec})) * ONE_SEC_NS
				+ (longint'({34'b0, stamp_nsec}) - longint'({34'b0, prev_nsec}));
			m = (ns < 0) ? -ns : ns;
			if (m > GAP_LIMIT_NS) m = GAP_LIMIT_NS;
			m = ((m / ONE_SEC_NS) << 32) + (((m % ONE_SEC_NS) << 32) / ONE_SEC_NS);
			dt = (ns < 0) ? -longint'(m) : longint'(m);
		end
		prev_sec = stamp_sec;
		prev_nsec = stamp_nsec;
		have_stamp = 1'b1;
		prod = longint'(turn_rate) * dt;
		ang = ph;
		if (midpoint) ang = ang + prod[48:17];
		x = (longint'(velocity_x) * CORDIC_GAIN) >>> 16;
		y = (longint'(velocity_y) * CORDIC_GAIN) >>> 16;
		// fold the left half-plane onto the right one
		if (ang[31] ^ ang[30]) begin
			x = -x;
			y = -y;
			ang = ang + 32'h80000000;
		end
		z = longint'($signed(ang));
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'({32'b0, arctan_lut[i]});
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'({32'b0, arctan_lut[i]});
			end
		end
		px = clamp_add(px, scale_by_dt(dt, x));
		py = clamp_add(py, scale_by_dt(dt, y));
		ph = ph + prod[47:16];
		r.x = px;
		r.y = py;
		r.h = ph;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t p;
		if (!arst_n) begin
			px = '0;
			py = '0;
			ph = '0;
			prev_sec = '0;
			prev_nsec = '0;
			have_stamp = 1'b0;
			midpoint = 1'b0;
			pose_q.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE:      midpoint = cfg_data[0];
					CFG_INIT_X:    px = cfg_data;
					CFG_INIT_Y:    py = cfg_data;
					CFG_INIT_HEAD: ph = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (pose_q.size() == 0) begin
					report("result with no request outstanding", pos_x, '0);
				end else begin
					p = pose_q.pop_front();
					if (pos_x !== p.x) report("pos_x", pos_x, p.x);
					if (pos_y !== p.y) report("pos_y", pos_y, p.y);
					if (heading !== p.h) report("heading", heading, p.h);
				end
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_RST) begin
					p.x = px;
					p.y = py;
					p.h = ph;
					px = new_x;
					py = new_y;
					ph = new_heading;
				end else begin
					p = integrate_pose();
				end
				pose_q.push_back(p);
			end
			pending = pose_q.size();
		end
	end

endmodule

>>> tb/tb.sv
// stimulus and verdict for the odometry integrator; depends on poi_pkg,
// planar_odometry_integrator_top and odometry_checker
`timescale 1ns / 1ps

module tb;
	import poi_pkg::*;

	localparam int STALL_LIMIT = 12000;
	localparam int LONG_HOLD = 1500;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func = FUNC_VEL;
	logic [31:0]          stamp_sec = '0;
	logic [29:0]          stamp_nsec = '0;
	logic signed [31:0]   velocity_x = '0;
	logic signed [31:0]   velocity_y = '0;
	logic signed [31:0]   turn_rate = '0;
	logic signed [31:0]   new_x = '0;
	logic signed [31:0]   new_y = '0;
	logic [31:0]          new_heading = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   pos_x;
	logic signed [31:0]   pos_y;
	logic [31:0]          heading;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE;
	logic [31:0]          cfg_data = '0;

	int   fail_count, pending, results_seen;
	int   requests_sent = 0;
	int   idle_cycles = 0;
	bit   quiet = 1'b0;
	bit   hold_req = 1'b0;
	logic [31:0] t_sec = '0;
	logic [29:0] t_nsec = '0;

	planar_odometry_integrator_top dut (.*);

	odometry_checker chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 65) return 0;
		if (r < 95) return $urandom_range(4, 1);
		return $urandom_range(150, 20);
	endfunction

	// receiver side, with an occasional long hold-off
	initial begin
		int stall, hold;
		stall = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold == 0) hold = LONG_HOLD;
			if (hold > 0) begin
				hold--;
				if (hold == 0) hold_req = 1'b0;
				out_ready = 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(99) < 30) stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", idle_cycles);
			$display("tb: errors");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(logic f, logic [31:0] s, logic [29:0] n, logic [31:0] vx,
			logic [31:0] vy, logic [31:0] w, logic [31:0] nx, logic [31:0] ny,
			logic [31:0] nh);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		stamp_sec = s;
		stamp_nsec = n;
		velocity_x = vx;
		velocity_y = vy;
		turn_rate = w;
		new_x = nx;
		new_y = ny;
		new_heading = nh;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic send_vel(logic [31:0] s, logic [29:0] n, logic [31:0] vx,
			logic [31:0] vy, logic [31:0] w);
		send_req(FUNC_VEL, s, n, vx, vy, w, $urandom, $urandom, $urandom);
	endtask

	task automatic send_pose(logic [31:0] nx, logic [31:0] ny, logic [31:0] nh);
		send_req(FUNC_RST, $urandom, 30'($urandom), $urandom, $urandom, $urandom,
			nx, ny, nh);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_vel();
		int r;
		r = $urandom_range(99);
		if (r < 55) return $signed($urandom_range(2 ** 20)) - 32'sd524288;
		if (r < 80) return $urandom;
		if (r < 90) return $signed($urandom_range(64)) - 32'sd32;
		return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
	endfunction

	// steps the running stamp forward by up to 50 ms
	task automatic advance_stamp();
		int step;
		step = $urandom_range(50000000);
		if (t_nsec + step > 999999999) begin
			t_nsec = 30'(t_nsec + step - 1000000000);
			t_sec = t_sec + 1;
		end else begin
			t_nsec = 30'(t_nsec + step);
		end
	endtask

	task automatic random_req();
		int r;
		r = $urandom_range(99);
		if (r < 82) begin
			advance_stamp();
			send_vel(t_sec, t_nsec, rand_vel(), rand_vel(),
				($urandom_range(9) == 0) ? $urandom
				: $signed($urandom_range(2 ** 18)) - 32'sd131072);
		end else if (r < 88) begin
			send_pose($urandom, $urandom, $urandom);
		end else begin
			// broken timing: backwards, large jumps, out-of-range nanoseconds
			t_sec = ($urandom_range(1)) ? $urandom : t_sec - $urandom_range(3);
			t_nsec = 30'($urandom_range(30'h3FFFFFFF));
			send_vel(t_sec, t_nsec, rand_vel(), rand_vel(), $urandom);
			if (t_nsec > 999999999) t_nsec = 0;
		end
	endtask

	initial begin
		logic [31:0] init_vals [4];
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset-time defaults first
		send_vel(32'd100, 30'd0, 32'h00010000, 32'h0, 32'h0);
		send_vel(32'd100, 30'd20000000, 32'h00010000, 32'h0, 32'h00004000);
		send_vel(32'd100, 30'd40000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_vel(32'd100, 30'd60000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_vel(32'd99, 30'd500000000, 32'h00020000, 32'hFFFF0000, 32'h00010000);
		send_vel(32'hFFFFFFFF, 30'd999999999, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
		send_vel(32'h0, 30'h3FFFFFFF, 32'h80000000, 32'h80000000, 32'h00008000);
		send_vel(32'h0, 30'h0, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF);
		send_pose(32'h7FFFFFF0, 32'h80000010, 32'hC0000000);
		send_vel(32'd1, 30'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
		send_pose(32'h0, 32'h0, 32'h40000000);
		send_vel(32'd2, 30'd0, 32'h00010000, 32'h00010000, 32'h0);
		send_pose(32'h0, 32'h0, 32'h80000000);
		send_vel(32'd3, 30'd0, 32'h00010000, 32'h0, 32'hFFFF0000);
		send_pose(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
		send_vel(32'd3, 30'd1, 32'h0, 32'h0, 32'h0);
		drain();
		write_reg(CFG_MODE, 32'd1);
		send_vel(32'd4, 30'd0, 32'h00010000, 32'h0, 32'h00010000);
		send_vel(32'd5, 30'd0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		drain();

		t_sec = 32'd10;
		t_nsec = 30'd0;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: init_vals = '{32'd0, 32'h0, 32'h0, 32'h0};
				1: init_vals = '{32'd1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
				2: init_vals = '{32'd0, 32'h80000000, 32'h7FFFFFFF, 32'h40000000};
				default: init_vals = '{$urandom, $urandom, $urandom, $urandom};
			endcase
			write_reg(CFG_MODE, init_vals[0]);
			write_reg(CFG_INIT_X, init_vals[1]);
			write_reg(CFG_INIT_Y, init_vals[2]);
			write_reg(CFG_INIT_HEAD, init_vals[3]);
			quiet = (ph == 5);
			for (int k = 0; k < 250; k++) begin
				if (ph == 2 && k == 40) hold_req = 1'b1;
				if (ph == 4 && k == 100) drain();
				random_req();
			end
		end

		drain();
		repeat (300) @(negedge clk);
		$display("covered %0d requests, %0d results over 9 register settings,",
			requests_sent, results_seen);
		$display("both modes, pose resets, stamp jumps and saturating extremes");
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
